// ===== rtl/pow_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pow_pkg;

    localparam int MAX_LANES = 4;
    localparam int VAL_W     = 16;
    localparam int ADDR_W    = 12;
    localparam int GRP_W     = 8;
    localparam int POS_W     = 10;
    localparam int WIN_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_W     = 10;

    localparam logic [CFG_IDX_W-1:0] CFG_OUT_HEIGHT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OUT_WIDTH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CHAN_GROUPS = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_POOL_FACTOR = 2'd3;

    localparam logic [9:0] OUT_HEIGHT_RST  = 10'd16;
    localparam logic [9:0] OUT_WIDTH_RST   = 10'd16;
    localparam logic [8:0] CHAN_GROUPS_RST = 9'd1;
    localparam logic [2:0] POOL_FACTOR_RST = 3'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] value_0;
        logic signed [VAL_W-1:0] value_1;
        logic signed [VAL_W-1:0] value_2;
        logic signed [VAL_W-1:0] value_3;
    } item_t;

    typedef struct packed {
        logic        [ADDR_W-1:0] in_row;
        logic        [ADDR_W-1:0] in_col;
        logic        [GRP_W-1:0]  chan_group;
        logic        [POS_W-1:0]  out_row;
        logic        [POS_W-1:0]  out_col;
        logic                     first_of_window;
        logic                     window_done;
        logic signed [VAL_W-1:0]  pooled_0;
        logic signed [VAL_W-1:0]  pooled_1;
        logic signed [VAL_W-1:0]  pooled_2;
        logic signed [VAL_W-1:0]  pooled_3;
    } result_t;

    // current walk position handed from the address walker
    typedef struct packed {
        logic [ADDR_W-1:0] in_row;
        logic [ADDR_W-1:0] in_col;
        logic [GRP_W-1:0]  chan_group;
        logic [POS_W-1:0]  out_row;
        logic [POS_W-1:0]  out_col;
        logic              first;
        logic              done;
    } walk_t;

endpackage

`default_nettype wire

// ===== rtl/pow_walk.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pow_walk (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pow_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pow_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                             advance,
    output pow_pkg::walk_t                        walk
);

    logic [9:0] out_height_reg;
    logic [9:0] out_width_reg;
    logic [8:0] chan_groups_reg;
    logic [2:0] pool_factor_reg;

    logic [pow_pkg::ADDR_W-1:0] base_row_reg, base_row_next;
    logic [pow_pkg::ADDR_W-1:0] base_col_reg, base_col_next;
    logic [pow_pkg::GRP_W-1:0]  group_reg, group_next;
    logic [pow_pkg::POS_W-1:0]  prow_reg, prow_next;
    logic [pow_pkg::POS_W-1:0]  pcol_reg, pcol_next;
    logic [pow_pkg::WIN_W-1:0]  wrow_reg, wrow_next;
    logic [pow_pkg::WIN_W-1:0]  wcol_reg, wcol_next;

    logic [2:0]                 pf;
    logic [pow_pkg::WIN_W-1:0]  pf_last;
    logic [pow_pkg::GRP_W-1:0]  cg_last;
    logic [pow_pkg::POS_W-1:0]  ow_last;
    logic [pow_pkg::POS_W-1:0]  oh_last;
    logic                       col_wrap;
    logic                       row_wrap;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_height_reg  <= pow_pkg::OUT_HEIGHT_RST;
            out_width_reg   <= pow_pkg::OUT_WIDTH_RST;
            chan_groups_reg <= pow_pkg::CHAN_GROUPS_RST;
            pool_factor_reg <= pow_pkg::POOL_FACTOR_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                pow_pkg::CFG_OUT_HEIGHT:  out_height_reg  <= cfg_data;
                pow_pkg::CFG_OUT_WIDTH:   out_width_reg   <= cfg_data;
                pow_pkg::CFG_CHAN_GROUPS: chan_groups_reg <= cfg_data[8:0];
                pow_pkg::CFG_POOL_FACTOR: pool_factor_reg <= cfg_data[2:0];
                default: ;
            endcase
        end
    end

    // limits: zero acts as one, oversized values clamp
    always_comb
    begin
        if (pool_factor_reg == 3'd0)
            pf = 3'd1;
        else if (pool_factor_reg > 3'd4)
            pf = 3'd4;
        else
            pf = pool_factor_reg;
        pf_last = 2'(pf - 3'd1);

        if (chan_groups_reg == 9'd0)
            cg_last = '0;
        else if (chan_groups_reg > 9'd256)
            cg_last = 8'd255;
        else
            cg_last = 8'(chan_groups_reg - 9'd1);

        ow_last = (out_width_reg == 10'd0) ? 10'd0 : out_width_reg - 10'd1;
        oh_last = (out_height_reg == 10'd0) ? 10'd0 : out_height_reg - 10'd1;
    end

    assign col_wrap = wcol_reg >= pf_last;
    assign row_wrap = wrow_reg >= pf_last;

    always_comb
    begin
        base_row_next = base_row_reg;
        base_col_next = base_col_reg;
        group_next    = group_reg;
        prow_next     = prow_reg;
        pcol_next     = pcol_reg;
        wrow_next     = wrow_reg;
        wcol_next     = wcol_reg;
        if (!col_wrap)
            wcol_next = wcol_reg + 2'd1;
        else
        begin
            wcol_next = '0;
            if (!row_wrap)
                wrow_next = wrow_reg + 2'd1;
            else
            begin
                wrow_next = '0;
                if (group_reg < cg_last)
                    group_next = group_reg + 8'd1;
                else
                begin
                    group_next = '0;
                    if (pcol_reg < ow_last)
                    begin
                        pcol_next     = pcol_reg + 10'd1;
                        base_col_next = base_col_reg + 12'(pf);
                    end
                    else
                    begin
                        pcol_next     = '0;
                        base_col_next = '0;
                        if (prow_reg < oh_last)
                        begin
                            prow_next     = prow_reg + 10'd1;
                            base_row_next = base_row_reg + 12'(pf);
                        end
                        else
                        begin
                            prow_next     = '0;
                            base_row_next = '0;
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_row_reg <= '0;
            base_col_reg <= '0;
            group_reg    <= '0;
            prow_reg     <= '0;
            pcol_reg     <= '0;
            wrow_reg     <= '0;
            wcol_reg     <= '0;
        end
        else if (advance)
        begin
            base_row_reg <= base_row_next;
            base_col_reg <= base_col_next;
            group_reg    <= group_next;
            prow_reg     <= prow_next;
            pcol_reg     <= pcol_next;
            wrow_reg     <= wrow_next;
            wcol_reg     <= wcol_next;
        end
    end

    assign walk.in_row     = base_row_reg + 12'(wrow_reg);
    assign walk.in_col     = base_col_reg + 12'(wcol_reg);
    assign walk.chan_group = group_reg;
    assign walk.out_row    = prow_reg;
    assign walk.out_col    = pcol_reg;
    assign walk.first      = (wrow_reg == '0) && (wcol_reg == '0);
    assign walk.done       = col_wrap && row_wrap;

endmodule

`default_nettype wire

// ===== rtl/pooled_order_window_max.sv =====
// Channel   Direction  Handshake                 Payload
// cfg       in         cfg_we                    cfg_index, cfg_data
// item      in         item_valid / item_stall   item (pow_pkg::item_t)
// result    out        result_valid / result_stall  result (pow_pkg::result_t)
//
// One result per item; the result register loads on the transfer and shows the result in the following cycle.
// An item is taken every cycle while item_stall is low; throughput is set by the result register alone.
// item_stall is high only while a result waits and result_stall is high.
// Reset clears the walk counters, the running maxima and the result valid.
`timescale 1ns / 1ps
`default_nettype none

module pooled_order_window_max #(
    parameter int LANES = pow_pkg::MAX_LANES
) (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             cfg_we,
    input  wire logic [pow_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [pow_pkg::CFG_W-1:0]        cfg_data,
    input  wire logic                             item_valid,
    output logic                                  item_stall,
    input  wire pow_pkg::item_t                   item,
    output logic                                  result_valid,
    input  wire logic                             result_stall,
    output pow_pkg::result_t                      result
);

    pow_pkg::walk_t   walk;
    pow_pkg::result_t result_reg;
    logic             valid_reg;
    logic             accept;

    logic signed [pow_pkg::VAL_W-1:0] lane_in  [pow_pkg::MAX_LANES];
    logic signed [pow_pkg::VAL_W-1:0] lane_max_next [pow_pkg::MAX_LANES];
    logic signed [pow_pkg::VAL_W-1:0] lane_max_reg [LANES];

    assign item_stall = valid_reg && result_stall;
    assign accept     = item_valid && !item_stall;

    pow_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .advance   (accept),
        .walk      (walk)
    );

    assign lane_in[0] = item.value_0;
    assign lane_in[1] = item.value_1;
    assign lane_in[2] = item.value_2;
    assign lane_in[3] = item.value_3;

    for (genvar l = 0; l < pow_pkg::MAX_LANES; l++)
    begin : g_lane
        if (l < LANES)
        begin : g_used
            assign lane_max_next[l] = (walk.first || lane_in[l] > lane_max_reg[l]) ?
                                      lane_in[l] : lane_max_reg[l];

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    lane_max_reg[l] <= '0;
                else if (accept)
                    lane_max_reg[l] <= lane_max_next[l];
            end
        end
        else
        begin : g_unused
            assign lane_max_next[l] = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (accept)
            valid_reg <= 1'b1;
        else if (!result_stall)
            valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            result_reg.in_row          <= walk.in_row;
            result_reg.in_col          <= walk.in_col;
            result_reg.chan_group      <= walk.chan_group;
            result_reg.out_row         <= walk.out_row;
            result_reg.out_col         <= walk.out_col;
            result_reg.first_of_window <= walk.first;
            result_reg.window_done     <= walk.done;
            result_reg.pooled_0        <= lane_max_next[0];
            result_reg.pooled_1        <= lane_max_next[1];
            result_reg.pooled_2        <= lane_max_next[2];
            result_reg.pooled_3        <= lane_max_next[3];
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

`default_nettype wire
